### hw/rtl/rgbab_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB565 / ARGB8565 alpha blend - shared types and constants
// Item layouts of the request and response channels and the pixel format
// codes used by the blend pipeline.
// ----------------------------------------------------------------------------
package rgbab_pkg;

   // Pixel format codes
   localparam logic FMT_RGB565   = 1'b0;
   localparam logic FMT_ARGB8565 = 1'b1;

   // Full-scale alpha / weight
   localparam logic [7:0] FULL_WEIGHT = 8'hFF;

   // Right shift of the 5-bit-weight shortcut blend
   localparam int unsigned SHORT_SHIFT = 5;

   // Request item: destination and source pixel with their blend weights
   typedef struct packed {
      logic        dst_format;
      logic [15:0] dst_rgb;
      logic [7:0]  dst_alpha;
      logic [7:0]  dst_weight;
      logic        src_format;
      logic [15:0] src_rgb;
      logic [7:0]  src_alpha;
      logic [7:0]  src_weight;
   } blend_req_type;

   // Response item: blended destination pixel
   typedef struct packed {
      logic [15:0] out_rgb;
      logic [7:0]  out_alpha;
      logic        weight_error;
   } blend_rsp_type;

endpackage
`default_nettype wire

### hw/rtl/rgb565_alpha_pixel_blend_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB565 / ARGB8565 alpha pixel blend
// Blends one source pixel into one destination pixel per item. Six register
// stages: alpha products, alpha divide, combined-alpha products, weight
// select, channel products, channel sum and divide.
// ----------------------------------------------------------------------------
// An accepted request item passes through every stage register in order.
// Throughput: 1 item per cycle unless stalled; each stage holds one item
// and a stalled stage still lets earlier stages move up into empty slots.
// Reset: synchronous; clears the stage valid bits only, so the pipeline
// comes out of reset empty and ready.
module rgb565_alpha_pixel_blend_top
   import rgbab_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire blend_req_type req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      blend_rsp_type rsp_data
);

   localparam int unsigned NUM_STAGES = 6;

   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_SRC,
      MODE_BLEND
   } rgb_mode_type;

   // Exact floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // ------------------------------------------------------------------
   // Stage valid bits and flow control
   // ------------------------------------------------------------------
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] stage_rdy;

   // A stage may load when it is empty or its item moves on
   always_comb begin
      stage_rdy[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k + 1];
      end
   end

   // Advance valid bits along with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_rdy[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (stage_rdy[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   assign req_stall = !stage_rdy[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   // ------------------------------------------------------------------
   // Stage 1: per-pixel alpha products and weight check
   // ------------------------------------------------------------------
   blend_req_type s1_req_ff;
   logic [15:0]   s1_pa2_ff, s1_pa2_in;
   logic [15:0]   s1_pa1_ff, s1_pa1_in;
   logic          s1_err_ff, s1_err_in;
   logic [8:0]    wsum;

   always_comb begin
      s1_pa2_in = {8'b0, req_data.src_alpha} * {8'b0, req_data.src_weight};
      s1_pa1_in = {8'b0, req_data.dst_alpha} * {8'b0, req_data.dst_weight};
      wsum      = {1'b0, req_data.dst_weight} + {1'b0, req_data.src_weight};
      s1_err_in = (wsum != {1'b0, FULL_WEIGHT});
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[1]) begin
         s1_req_ff <= req_data;
         s1_pa2_ff <= s1_pa2_in;
         s1_pa1_ff <= s1_pa1_in;
         s1_err_ff <= s1_err_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: scale the alpha products down by 255
   // ------------------------------------------------------------------
   blend_req_type s2_req_ff;
   logic [7:0]    s2_a2_ff, s2_a2_in;
   logic [7:0]    s2_a1_ff, s2_a1_in;
   logic          s2_err_ff;

   assign s2_a2_in = div255(s1_pa2_ff);
   assign s2_a1_in = div255(s1_pa1_ff);

   always_ff @(posedge clock) begin
      if (stage_rdy[2]) begin
         s2_req_ff <= s1_req_ff;
         s2_a2_ff  <= s2_a2_in;
         s2_a1_ff  <= s2_a1_in;
         s2_err_ff <= s1_err_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: combined destination weight and output alpha products
   // ------------------------------------------------------------------
   blend_req_type s3_req_ff;
   logic [7:0]    s3_a2_ff;
   logic [15:0]   s3_pas_ff, s3_pas_in;
   logic [15:0]   s3_poa_ff, s3_poa_in;
   logic          s3_err_ff;
   logic [7:0]    inv_a2, inv_a1;

   always_comb begin
      inv_a2    = FULL_WEIGHT - s2_a2_ff;
      inv_a1    = FULL_WEIGHT - s2_a1_ff;
      s3_pas_in = {8'b0, s2_a1_ff} * {8'b0, inv_a2};
      s3_poa_in = {8'b0, inv_a2} * {8'b0, inv_a1};
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[3]) begin
         s3_req_ff <= s2_req_ff;
         s3_a2_ff  <= s2_a2_ff;
         s3_pas_ff <= s3_pas_in;
         s3_poa_ff <= s3_poa_in;
         s3_err_ff <= s2_err_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: pick the result mode, channel weights and output alpha
   // ------------------------------------------------------------------
   rgb_mode_type s4_mode_ff, s4_mode_in;
   logic         s4_short_ff, s4_short_in;
   logic [7:0]   s4_wd_ff, s4_wd_in;
   logic [7:0]   s4_ws_ff, s4_ws_in;
   logic [7:0]   s4_alpha_ff, s4_alpha_in;
   logic         s4_err_ff;
   logic [15:0]  s4_drgb_ff;
   logic [15:0]  s4_srgb_ff;
   logic [7:0]   comb_as, comb_oa;
   logic [7:0]   dw, sw;

   always_comb begin
      dw          = s3_req_ff.dst_weight;
      sw          = s3_req_ff.src_weight;
      comb_as     = div255(s3_pas_ff);
      comb_oa     = FULL_WEIGHT - div255(s3_poa_ff);
      s4_mode_in  = MODE_PASS;
      s4_short_in = 1'b0;
      s4_wd_in    = '0;
      s4_ws_in    = '0;
      s4_alpha_in = s3_req_ff.dst_alpha;
      if (!s3_err_ff) begin
         if (s3_req_ff.dst_format == FMT_RGB565 && s3_req_ff.src_format == FMT_RGB565) begin
            // Both opaque: 5-bit weight shortcut
            if (dw == FULL_WEIGHT) begin
               s4_mode_in = MODE_PASS;
            end else if (sw == FULL_WEIGHT) begin
               s4_mode_in = MODE_SRC;
            end else begin
               s4_mode_in  = MODE_BLEND;
               s4_short_in = 1'b1;
               s4_wd_in    = {3'b0, dw[7:3]};
               s4_ws_in    = {3'b0, sw[7:3]};
            end
         end else if (s3_req_ff.dst_format == FMT_RGB565) begin
            // Source alpha folded into its weight
            if (dw != FULL_WEIGHT) begin
               s4_mode_in = MODE_BLEND;
               s4_wd_in   = FULL_WEIGHT - s3_a2_ff;
               s4_ws_in   = s3_a2_ff;
            end
         end else if (s3_req_ff.src_format == FMT_RGB565) begin
            // Opaque source onto alpha destination
            if (dw != FULL_WEIGHT && sw != 8'd0) begin
               s4_mode_in  = MODE_BLEND;
               s4_alpha_in = FULL_WEIGHT;
               s4_wd_in    = FULL_WEIGHT - sw;
               s4_ws_in    = sw;
            end
         end else begin
            // Both carry alpha
            if (dw != FULL_WEIGHT && s3_a2_ff != 8'd0) begin
               s4_mode_in  = MODE_BLEND;
               s4_alpha_in = comb_oa;
               s4_wd_in    = comb_as;
               s4_ws_in    = s3_a2_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[4]) begin
         s4_mode_ff  <= s4_mode_in;
         s4_short_ff <= s4_short_in;
         s4_wd_ff    <= s4_wd_in;
         s4_ws_ff    <= s4_ws_in;
         s4_alpha_ff <= s4_alpha_in;
         s4_err_ff   <= s3_err_ff;
         s4_drgb_ff  <= s3_req_ff.dst_rgb;
         s4_srgb_ff  <= s3_req_ff.src_rgb;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: weighted channel products (lane 2 red, 1 green, 0 blue)
   // ------------------------------------------------------------------
   rgb_mode_type     s5_mode_ff;
   logic             s5_short_ff;
   logic [7:0]       s5_alpha_ff;
   logic             s5_err_ff;
   logic [15:0]      s5_drgb_ff;
   logic [15:0]      s5_srgb_ff;
   logic [2:0][13:0] s5_pd_ff, s5_pd_in;
   logic [2:0][13:0] s5_ps_ff, s5_ps_in;

   always_comb begin
      s5_pd_in[2] = {9'b0, s4_drgb_ff[15:11]} * {6'b0, s4_wd_ff};
      s5_pd_in[1] = {8'b0, s4_drgb_ff[10:5]}  * {6'b0, s4_wd_ff};
      s5_pd_in[0] = {9'b0, s4_drgb_ff[4:0]}   * {6'b0, s4_wd_ff};
      s5_ps_in[2] = {9'b0, s4_srgb_ff[15:11]} * {6'b0, s4_ws_ff};
      s5_ps_in[1] = {8'b0, s4_srgb_ff[10:5]}  * {6'b0, s4_ws_ff};
      s5_ps_in[0] = {9'b0, s4_srgb_ff[4:0]}   * {6'b0, s4_ws_ff};
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[5]) begin
         s5_mode_ff  <= s4_mode_ff;
         s5_short_ff <= s4_short_ff;
         s5_alpha_ff <= s4_alpha_ff;
         s5_err_ff   <= s4_err_ff;
         s5_drgb_ff  <= s4_drgb_ff;
         s5_srgb_ff  <= s4_srgb_ff;
         s5_pd_ff    <= s5_pd_in;
         s5_ps_ff    <= s5_ps_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: sum, scale and select the response item
   // ------------------------------------------------------------------
   blend_rsp_type   rsp_data_ff, rsp_data_in;
   logic [2:0][14:0] lane_sum;
   logic [2:0][7:0]  lane_q;
   logic [15:0]      blend_rgb;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_sum[k] = {1'b0, s5_pd_ff[k]} + {1'b0, s5_ps_ff[k]};
         if (s5_short_ff) begin
            lane_q[k] = 8'(lane_sum[k] >> SHORT_SHIFT);
         end else begin
            lane_q[k] = div255({1'b0, lane_sum[k]});
         end
      end
      blend_rgb = {lane_q[2][4:0], lane_q[1][5:0], lane_q[0][4:0]};
      rsp_data_in.out_alpha    = s5_alpha_ff;
      rsp_data_in.weight_error = s5_err_ff;
      if (s5_mode_ff == MODE_BLEND) begin
         rsp_data_in.out_rgb = blend_rgb;
      end else if (s5_mode_ff == MODE_SRC) begin
         rsp_data_in.out_rgb = s5_srgb_ff;
      end else begin
         rsp_data_in.out_rgb = s5_drgb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[6]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

`ifndef ASSERT_OFF
   // A weight error always leaves the destination untouched
   a_err_pass: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (!s4_err_ff || s4_mode_ff == MODE_PASS))
      else $error("weight error item not in pass mode");

   // Divide-by-255 weights never exceed full scale together
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[4] && s4_mode_ff == MODE_BLEND && !s4_short_ff)
         |-> ({1'b0, s4_wd_ff} + {1'b0, s4_ws_ff} <= {1'b0, FULL_WEIGHT}))
      else $error("blend weights exceed full scale");

   // Input stalls only when every stage holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled with an empty stage");

   // An item handed on from stage 1 shows up in stage 2
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[1] && stage_rdy[2]) |=> valid_ff[2])
      else $error("item lost between stage 1 and stage 2");
`endif

endmodule
`default_nettype wire
